[hdl/preemptive_priority_scheduler_macros.svh]
// Assertion macros used by the scheduler checker
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define PPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// next-cycle implication
`define PPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

[hdl/pps_pkg.sv]
// Shared types and constants of the priority scheduler
package pps_pkg;

	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] remaining;
		logic [15:0] burst;
		logic [7:0]  prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic clear;
		logic valid;
	} pick_ctl_t;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

endpackage

[hdl/pps_ram.sv]
// Generic simple dual-port RAM with registered read
module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/pps_pick.sv]
// Running best-candidate selection over the job table scan
module pps_pick import pps_pkg::*; #(
	parameter int IW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pick_ctl_t     ctl,
	input  entry_t        rd_entry,
	input  logic [IW-1:0] rd_idx,
	input  logic [31:0]   now,
	output logic          have,
	output entry_t        best,
	output logic [IW-1:0] best_idx
);

	logic   have_q;
	entry_t best_q;
	logic [IW-1:0] best_idx_q;
	logic   elig;
	logic   better;

	assign elig = ({16'b0, rd_entry.arrival} <= now) && (rd_entry.remaining != 16'd0);
	// strict compares: on a full tie the earlier slot stays
	assign better = !have_q || (rd_entry.prio < best_q.prio) ||
		((rd_entry.prio == best_q.prio) && (rd_entry.arrival < best_q.arrival));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.clear) begin
			have_q <= 1'b0;
		end else if (ctl.valid && elig && better) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clear && ctl.valid && elig && better) begin
			best_q     <= rd_entry;
			best_idx_q <= rd_idx;
		end
	end

	assign have     = have_q;
	assign best     = best_q;
	assign best_idx = best_idx_q;

endmodule

[hdl/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler: job table in RAM, scan-and-update sequencer
//
// Requests enter on start while busy is low; action selects load or tick.
// A load writes one job into the next free table slot and answers the cycle
// after it is taken and leaves the sequencer idle for the next request; a zero
// burst or a full table is flagged in load_rejected and changes nothing.
// A tick reads the table one slot per cycle through the RAM's single read
// port, keeping the best candidate, then writes the chosen job's remaining
// service back in the update state. A tick with no completion answers from
// there; a completing tick goes on through the turnaround, waiting and
// running-total arithmetic states before it answers.
// Each result shows for one cycle under result_valid; the receiver cannot
// stall, so there is no holding stage. busy stays high from the cycle after
// a tick is taken until its result appears.
// Reset clears counters, time and totals; the table itself is not cleared,
// only slots below the loaded count are ever read.
module preemptive_priority_scheduler import pps_pkg::*; #(
	parameter int MAX_PROCS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [15:0] arrival_time,
	input  logic [15:0] burst_time,
	input  logic [7:0]  job_priority,
	output logic        result_valid,
	output logic        load_rejected,
	output logic        ran,
	output logic [4:0]  job_number,
	output logic [31:0] time_now,
	output logic        finished,
	output logic [31:0] completion_time,
	output logic [31:0] turnaround,
	output logic [31:0] waiting,
	output logic        all_done,
	output logic [31:0] total_turnaround,
	output logic [31:0] total_waiting
);

	localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CW = $clog2(MAX_PROCS + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_UPD, ST_TAT, ST_WAIT, ST_SUM
	} state_t;

	state_t state_q;

	logic [CW-1:0] loaded_q, completed_q, scan_cnt_q;
	logic [31:0]   time_q, sum_tat_q, sum_wait_q, tat_q, wait_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;

	logic        res_valid_q, rej_q, ran_q, fin_q, all_done_q;
	logic [4:0]  job_q;
	logic [31:0] time_out_q, ct_q, tat_out_q, wait_out_q, tot_tat_q, tot_wait_q;

	logic          accept, load_ok, issue_rd, ram_we, res_fire;
	logic [IW-1:0] ram_waddr;
	entry_t        ram_wdata, new_entry, upd_entry, rd_entry, best;
	logic [ENTRY_W-1:0] ram_rdata;
	logic          have;
	logic [IW-1:0] best_idx;
	pick_ctl_t     pick_ctl;
	logic [31:0]   time_inc;
	logic [15:0]   rem_dec;
	logic [IW:0]   job_full;
	logic [32:0]   wait_diff, tat_sum, wait_sum;
	logic [31:0]   wait_val, tat_sat, wait_sat;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign load_ok  = (burst_time != 16'd0) && (loaded_q != CW'(MAX_PROCS));
	assign issue_rd = (state_q == ST_SCAN) && (scan_cnt_q != loaded_q);

	assign new_entry = '{arrival: arrival_time, remaining: burst_time,
		burst: burst_time, prio: job_priority};
	assign rem_dec   = best.remaining - 16'd1;
	always_comb begin
		upd_entry = best;
		upd_entry.remaining = rem_dec;
	end

	// loads write only from idle, updates only after the scan, so a read and
	// a write never meet on the same slot
	assign ram_we    = (accept && (action == ACT_LOAD) && load_ok) ||
		((state_q == ST_UPD) && have);
	assign ram_waddr = (state_q == ST_UPD) ? best_idx : loaded_q[IW-1:0];
	assign ram_wdata = (state_q == ST_UPD) ? upd_entry : new_entry;
	assign rd_entry  = entry_t'(ram_rdata);

	assign pick_ctl = '{clear: accept && (action == ACT_TICK), valid: rd_vld_s1};

	// result strobe: a load, a tick that finishes nothing, or the last sum step
	assign res_fire = (accept && (action == ACT_LOAD)) ||
		((state_q == ST_UPD) && !(have && (rem_dec == 16'd0))) ||
		(state_q == ST_SUM);

	assign time_inc = (time_q == TIME_MAX) ? time_q : time_q + 32'd1;
	assign job_full = {1'b0, best_idx} + (IW+1)'(1);

	assign wait_diff = {1'b0, tat_q} - {17'b0, best.burst};
	assign wait_val  = wait_diff[32] ? 32'd0 : wait_diff[31:0];
	assign tat_sum   = {1'b0, sum_tat_q} + {1'b0, tat_q};
	assign tat_sat   = tat_sum[32] ? TIME_MAX : tat_sum[31:0];
	assign wait_sum  = {1'b0, sum_wait_q} + {1'b0, wait_q};
	assign wait_sat  = wait_sum[32] ? TIME_MAX : wait_sum[31:0];

	pps_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_PROCS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue_rd),
		.raddr(scan_cnt_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	pps_pick #(
		.IW(IW)
	) u_pick (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (pick_ctl),
		.rd_entry(rd_entry),
		.rd_idx  (rd_idx_s1),
		.now     (time_q),
		.have    (have),
		.best    (best),
		.best_idx(best_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			loaded_q    <= '0;
			completed_q <= '0;
			scan_cnt_q  <= '0;
			time_q      <= '0;
			sum_tat_q   <= '0;
			sum_wait_q  <= '0;
			tat_q       <= '0;
			wait_q      <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			res_valid_q <= 1'b0;
			rej_q       <= 1'b0;
			ran_q       <= 1'b0;
			fin_q       <= 1'b0;
			all_done_q  <= 1'b0;
			job_q       <= '0;
			time_out_q  <= '0;
			ct_q        <= '0;
			tat_out_q   <= '0;
			wait_out_q  <= '0;
			tot_tat_q   <= '0;
			tot_wait_q  <= '0;
		end else begin
			res_valid_q <= res_fire;
			rd_vld_s1   <= issue_rd;
			rd_idx_s1   <= scan_cnt_q[IW-1:0];
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action == ACT_LOAD) begin
							rej_q       <= !load_ok;
							ran_q       <= 1'b0;
							job_q       <= '0;
							time_out_q  <= time_q;
							fin_q       <= 1'b0;
							ct_q        <= '0;
							tat_out_q   <= '0;
							wait_out_q  <= '0;
							all_done_q  <= load_ok ? (completed_q == loaded_q + CW'(1)) :
								(completed_q == loaded_q);
							tot_tat_q   <= sum_tat_q;
							tot_wait_q  <= sum_wait_q;
							if (load_ok)
								loaded_q <= loaded_q + CW'(1);
						end else begin
							scan_cnt_q <= '0;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issue_rd)
						scan_cnt_q <= scan_cnt_q + CW'(1);
					else if (!rd_vld_s1)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					time_q <= time_inc;
					if (have && (rem_dec == 16'd0)) begin
						state_q <= ST_TAT;
					end else begin
						rej_q       <= 1'b0;
						ran_q       <= have;
						job_q       <= have ? 5'(job_full) : 5'd0;
						time_out_q  <= time_inc;
						fin_q       <= 1'b0;
						ct_q        <= '0;
						tat_out_q   <= '0;
						wait_out_q  <= '0;
						all_done_q  <= (completed_q == loaded_q);
						tot_tat_q   <= sum_tat_q;
						tot_wait_q  <= sum_wait_q;
						state_q     <= ST_IDLE;
					end
				end
				ST_TAT: begin
					tat_q   <= time_q - {16'b0, best.arrival};
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					wait_q    <= wait_val;
					sum_tat_q <= tat_sat;
					state_q   <= ST_SUM;
				end
				ST_SUM: begin
					sum_wait_q  <= wait_sat;
					completed_q <= completed_q + CW'(1);
					rej_q       <= 1'b0;
					ran_q       <= 1'b1;
					job_q       <= 5'(job_full);
					time_out_q  <= time_q;
					fin_q       <= 1'b1;
					ct_q        <= time_q;
					tat_out_q   <= tat_q;
					wait_out_q  <= wait_q;
					all_done_q  <= (completed_q + CW'(1) == loaded_q);
					tot_tat_q   <= sum_tat_q;
					tot_wait_q  <= wait_sat;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid     = res_valid_q;
	assign load_rejected    = rej_q;
	assign ran              = ran_q;
	assign job_number       = job_q;
	assign time_now         = time_out_q;
	assign finished         = fin_q;
	assign completion_time  = ct_q;
	assign turnaround       = tat_out_q;
	assign waiting          = wait_out_q;
	assign all_done         = all_done_q;
	assign total_turnaround = tot_tat_q;
	assign total_waiting    = tot_wait_q;

endmodule

[hdl/pps_checker.sv]
// Port-level checks for the priority scheduler, bound to the top level
`include "preemptive_priority_scheduler_macros.svh"

module pps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        action,
	input logic        result_valid,
	input logic        load_rejected,
	input logic        ran,
	input logic        finished,
	input logic [4:0]  job_number
);

	// every taken request either answers next cycle or is still in work
	`PPS_ASSERT_NEXT(a_req_progress, start && !busy, result_valid || busy)
	// a tick request always occupies the sequencer
	`PPS_ASSERT_NEXT(a_tick_busy, start && !busy && action, busy)
	// results only appear once the sequencer is free again
	`PPS_ASSERT_NOW(a_res_idle, result_valid, !busy)
	// a completion implies a job ran, and a run is never a rejected load
	`PPS_ASSERT_NOW(a_fin_ran, result_valid && finished, ran && !load_rejected)
	// a result with no run names no job and finishes nothing
	`PPS_ASSERT_NOW(a_idle_tick, result_valid && !ran, job_number == 5'd0 && !finished)

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

[dv/preemptive_priority_scheduler_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the preemptive priority scheduler: directed and random requests
module preemptive_priority_scheduler_tb;
	import pps_pkg::*;

	localparam int JOB_SLOTS = 16;

	typedef struct packed {
		logic        load_rejected;
		logic        ran;
		logic [4:0]  job_number;
		logic [31:0] time_now;
		logic        finished;
		logic [31:0] completion_time;
		logic [31:0] turnaround;
		logic [31:0] waiting;
		logic        all_done;
		logic [31:0] total_turnaround;
		logic [31:0] total_waiting;
	} job_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        action = ACT_LOAD;
	logic [15:0] arrival_time = '0;
	logic [15:0] burst_time = '0;
	logic [7:0]  job_priority = '0;
	logic        busy;
	logic        result_valid;
	logic        load_rejected;
	logic        ran;
	logic [4:0]  job_number;
	logic [31:0] time_now;
	logic        finished;
	logic [31:0] completion_time;
	logic [31:0] turnaround;
	logic [31:0] waiting;
	logic        all_done;
	logic [31:0] total_turnaround;
	logic [31:0] total_waiting;

	// scheduler state as the testbench sees it
	logic [15:0] slot_arrival [JOB_SLOTS];
	logic [15:0] slot_left [JOB_SLOTS];
	logic [15:0] slot_burst [JOB_SLOTS];
	logic [7:0]  slot_prio [JOB_SLOTS];
	int          jobs_loaded = 0;
	int          jobs_done = 0;
	logic [31:0] sched_time = '0;
	logic [31:0] sum_tat = '0;
	logic [31:0] sum_wait = '0;

	job_report_t pending_reports[$];
	job_report_t want_report;
	int          error_count = 0;
	int          requests_sent = 0;
	int          reports_checked = 0;
	int          loads_refused = 0;

	always #5 clk = ~clk;

	preemptive_priority_scheduler #(
		.MAX_PROCS(JOB_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.arrival_time(arrival_time),
		.burst_time(burst_time),
		.job_priority(job_priority),
		.result_valid(result_valid),
		.load_rejected(load_rejected),
		.ran(ran),
		.job_number(job_number),
		.time_now(time_now),
		.finished(finished),
		.completion_time(completion_time),
		.turnaround(turnaround),
		.waiting(waiting),
		.all_done(all_done),
		.total_turnaround(total_turnaround),
		.total_waiting(total_waiting)
	);

	function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? TIME_MAX : s[31:0];
	endfunction

	// one load or tick applied to the scheduler state; returns the report it gives
	function automatic job_report_t schedule_step(logic act, logic [15:0] arr,
			logic [15:0] burst, logic [7:0] prio);
		job_report_t r;
		int          pick;
		bit          found;
		logic [31:0] tat;
		logic [31:0] wait_t;
		r = '0;
		pick = 0;
		found = 1'b0;
		if (act == ACT_LOAD) begin
			if (burst == 16'd0 || jobs_loaded >= JOB_SLOTS) begin
				r.load_rejected = 1'b1;
				loads_refused++;
			end else begin
				slot_arrival[jobs_loaded] = arr;
				slot_left[jobs_loaded] = burst;
				slot_burst[jobs_loaded] = burst;
				slot_prio[jobs_loaded] = prio;
				jobs_loaded++;
			end
		end else begin
			for (int i = 0; i < jobs_loaded; i++) begin
				if (32'(slot_arrival[i]) <= sched_time && slot_left[i] != 16'd0) begin
					if (!found || slot_prio[i] < slot_prio[pick] ||
							(slot_prio[i] == slot_prio[pick] &&
							slot_arrival[i] < slot_arrival[pick])) begin
						pick = i;
						found = 1'b1;
					end
				end
			end
			if (sched_time != TIME_MAX)
				sched_time = sched_time + 32'd1;
			if (found) begin
				r.ran = 1'b1;
				r.job_number = 5'(pick + 1);
				slot_left[pick] = slot_left[pick] - 16'd1;
				if (slot_left[pick] == 16'd0) begin
					tat = sched_time - 32'(slot_arrival[pick]);
					// only short once time has hit its ceiling
					wait_t = (tat >= 32'(slot_burst[pick])) ?
						tat - 32'(slot_burst[pick]) : 32'd0;
					r.finished = 1'b1;
					r.completion_time = sched_time;
					r.turnaround = tat;
					r.waiting = wait_t;
					sum_tat = sat_add32(sum_tat, tat);
					sum_wait = sat_add32(sum_wait, wait_t);
					jobs_done++;
				end
			end
		end
		r.time_now = sched_time;
		r.all_done = (jobs_done == jobs_loaded);
		r.total_turnaround = sum_tat;
		r.total_waiting = sum_wait;
		return r;
	endfunction

	// start is left high on return so back-to-back requests need no gap
	task automatic send_request(logic act, logic [15:0] arr, logic [15:0] burst,
			logic [7:0] prio);
		start <= 1'b1;
		action <= act;
		arrival_time <= arr;
		burst_time <= burst;
		job_priority <= prio;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_reports.push_back(schedule_step(act, arr, burst, prio));
		requests_sent++;
	endtask

	task automatic sender_pause(int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic send_tick();
		send_request(ACT_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
				$time, name, want, want, got, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: result with no request outstanding, expected none, got job %0d",
					$time, job_number);
				error_count++;
			end else begin
				want_report = pending_reports.pop_front();
				reports_checked++;
				check_field("load_rejected", 32'(want_report.load_rejected), 32'(load_rejected));
				check_field("ran", 32'(want_report.ran), 32'(ran));
				check_field("job_number", 32'(want_report.job_number), 32'(job_number));
				check_field("time_now", want_report.time_now, time_now);
				check_field("finished", 32'(want_report.finished), 32'(finished));
				check_field("completion_time", want_report.completion_time, completion_time);
				check_field("turnaround", want_report.turnaround, turnaround);
				check_field("waiting", want_report.waiting, waiting);
				check_field("all_done", 32'(want_report.all_done), 32'(all_done));
				check_field("total_turnaround", want_report.total_turnaround, total_turnaround);
				check_field("total_waiting", want_report.total_waiting, total_waiting);
			end
		end
	end

	task automatic test_empty_table();
		send_tick();
		send_request(ACT_LOAD, 16'hFFFF, 16'd0, 8'hFF);
		send_tick();
	endtask

	task automatic test_preemption_and_ties();
		// equal priority and arrival: lower slot wins
		send_request(ACT_LOAD, 16'd0, 16'd3, 8'd5);
		send_request(ACT_LOAD, 16'd0, 16'd1, 8'd5);
		send_tick();
		// urgent job loaded mid-run, not yet arrived on the next tick
		send_request(ACT_LOAD, 16'd4, 16'd2, 8'd0);
		repeat (5) send_tick();
		// equal priority: the later slot arrived first and goes first
		send_request(ACT_LOAD, 16'd7, 16'd1, 8'd7);
		send_request(ACT_LOAD, 16'd6, 16'd1, 8'd7);
		repeat (2) send_tick();
		send_request(ACT_LOAD, 16'd0, 16'd2, 8'd255);
		repeat (3) send_tick();
	endtask

	// mostly ticks; valid loads until the table holds load_cap jobs
	task automatic test_random_traffic(int n_items, int idle_pct, int load_cap);
		logic [15:0] arr;
		logic [15:0] burst;
		logic [7:0]  prio;
		int          lo;
		int          roll;
		for (int n = 0; n < n_items; n++) begin
			roll = $urandom_range(99);
			if (roll < 22) begin
				lo = (sched_time > 32'd10) ? int'(sched_time) - 10 : 0;
				arr = (lo + 24 > 65535) ? 16'hFFFF : 16'(lo + $urandom_range(0, 24));
				burst = ($urandom_range(3) == 0) ? 16'd1 : 16'($urandom_range(1, 12));
				prio = $urandom_range(1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
				if (jobs_loaded >= JOB_SLOTS) begin
					arr = 16'($urandom);
					burst = 16'($urandom);
					prio = 8'($urandom);
				end else if (jobs_loaded >= load_cap || roll < 3) begin
					arr = 16'($urandom);
					burst = 16'd0;
				end
				send_request(ACT_LOAD, arr, burst, prio);
			end else begin
				send_tick();
			end
			sender_pause(idle_pct);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_preemption_and_ties();
		test_random_traffic(170, 26, 10);
		test_random_traffic(160, 53, 13);
		test_random_traffic(170, 0, JOB_SLOTS);
		start <= 1'b0;

		while (pending_reports.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d requests (%0d loads turned away), checked %0d reports.",
			requests_sent, loads_refused, reports_checked);
		$display("Jobs finished: %0d of %0d loaded; scheduler time reached %0d.",
			jobs_done, jobs_loaded, sched_time);
		if (error_count == 0 && pending_reports.size() == 0) begin
			$display("** preemptive_priority_scheduler: PASSED **");
		end else begin
			$display("** preemptive_priority_scheduler: FAILED **");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d reports outstanding.", pending_reports.size());
		$display("** preemptive_priority_scheduler: FAILED **");
		$finish;
	end

endmodule
